### rtl/chp_pkg.sv
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types, codes and character constants of the chat header parser.
// ----------------------------------------------------------------------------
package chp_pkg;

  // default sizes
  localparam int NAME_LEN_DEF    = 4;
  localparam int MAX_CONTENT_DEF = 256;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

  // parse phases
  localparam logic [2:0] PH_SENDER     = 3'd0;
  localparam logic [2:0] PH_SEEK_MARK  = 3'd1;
  localparam logic [2:0] PH_DEST_FIRST = 3'd2;
  localparam logic [2:0] PH_DEST       = 3'd3;
  localparam logic [2:0] PH_SEEK_COLON = 3'd4;
  localparam logic [2:0] PH_COUNTER    = 3'd5;
  localparam logic [2:0] PH_TTL        = 3'd6;
  localparam logic [2:0] PH_CONTENT    = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SENDER  = 3'd1;
  localparam logic [2:0] ST_MARKER  = 3'd2;
  localparam logic [2:0] ST_GROUPBC = 3'd3;
  localparam logic [2:0] ST_DEST    = 3'd4;
  localparam logic [2:0] ST_COUNTER = 3'd5;
  localparam logic [2:0] ST_TTL     = 3'd6;
  localparam logic [2:0] ST_LENGTH  = 3'd7;

  // destination kinds
  localparam logic [1:0] KIND_BCAST   = 2'd0;
  localparam logic [1:0] KIND_CONTACT = 2'd1;
  localparam logic [1:0] KIND_GROUP   = 2'd2;

  // result item kinds
  localparam logic ITEM_CONTENT = 1'b0;
  localparam logic ITEM_HEADER  = 1'b1;

  // number scan stages
  localparam logic [1:0] NS_START  = 2'd0;
  localparam logic [1:0] NS_SIGN   = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;
  localparam logic [1:0] NS_DONE   = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;

  // number limits
  localparam logic [5:0]  TEXT_MAX = 6'd31;
  localparam logic [19:0] TTL_SAT  = 20'd65536;

  // one result item
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  content_char;
    logic [2:0]  status;
    logic [1:0]  dest_kind;
    logic [31:0] sender_name;
    logic [31:0] dest_name;
    logic [31:0] msg_counter;
    logic        ttl_present;
    logic [15:0] ttl_value;
    logic [8:0]  content_length;
    logic        run_end;
  } chp_result_t;

  // results produced by one byte, r0 first
  typedef struct packed {
    logic [1:0]  cnt;
    chp_result_t r0;
    chp_result_t r1;
  } chp_push_t;

endpackage

### rtl/chp_if.sv
// ----------------------------------------------------------------------------
// chp_if
// Valid/ready channels of the chat header parser: byte input and results.
// ----------------------------------------------------------------------------
interface chp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  content_char;
  logic [2:0]  status;
  logic [1:0]  dest_kind;
  logic [31:0] sender_name;
  logic [31:0] dest_name;
  logic [31:0] msg_counter;
  logic        ttl_present;
  logic [15:0] ttl_value;
  logic [8:0]  content_length;
  logic        run_end;

  modport source (
    output valid, input ready,
    output item_kind, output content_char, output status, output dest_kind,
    output sender_name, output dest_name, output msg_counter,
    output ttl_present, output ttl_value, output content_length, output run_end
  );
  modport sink (
    input valid, output ready,
    input item_kind, input content_char, input status, input dest_kind,
    input sender_name, input dest_name, input msg_counter,
    input ttl_present, input ttl_value, input content_length, input run_end
  );
endinterface

### rtl/chat_header_parser.sv
// ----------------------------------------------------------------------------
// chat_header_parser
// Chat frame header parser: bytes in, content bytes and one header out.
// ----------------------------------------------------------------------------
// Usage
//   in_bus  takes one frame byte per transfer; last_byte marks the frame end.
//   out_bus gives one result per transfer: content bytes (item_kind 0) as the
//   content is seen, then one header (item_kind 1) on the last byte.
//   A byte is registered on transfer and parsed the next cycle; its results
//   are written into an 8-entry queue, and the first result can be taken
//   once it is written there. One byte per cycle is sustained while
//   in_bus.ready stays high; a last byte inside the content yields two
//   results, and the queue drains them at one per cycle, set by the single result port.
//   When the receiver stalls, results wait in the queue; in_bus.ready drops
//   once fewer than two free entries remain behind the byte held in the
//   input register, so nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and returns the parser
//   to the start of a frame.
// ----------------------------------------------------------------------------
module chat_header_parser #(
  parameter int NAME_LEN    = chp_pkg::NAME_LEN_DEF,
  parameter int MAX_CONTENT = chp_pkg::MAX_CONTENT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  chp_in_if.sink     in_bus,
  chp_out_if.source  out_bus
);
  import chp_pkg::*;

  chp_push_t         push;
  logic [LVL_W-1:0]  fifo_level;

  // parser with its input register
  chp_parser #(
    .NAME_LEN    (NAME_LEN),
    .MAX_CONTENT (MAX_CONTENT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .fifo_level (fifo_level),
    .push       (push)
  );

  // result queue
  chp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .fifo_level (fifo_level),
    .out_bus    (out_bus)
  );

endmodule

### rtl/chp_parser.sv
// ----------------------------------------------------------------------------
// chp_parser
// Input register and frame parser: one byte per cycle while ready, up to two results.
// ----------------------------------------------------------------------------
module chp_parser #(
  parameter int NAME_LEN    = chp_pkg::NAME_LEN_DEF,
  parameter int MAX_CONTENT = chp_pkg::MAX_CONTENT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  chp_in_if.sink                     in_bus,
  input  logic [chp_pkg::LVL_W-1:0]  fifo_level,
  output chp_pkg::chp_push_t         push
);
  import chp_pkg::*;

  localparam int         CW        = $clog2(MAX_CONTENT + 1);
  localparam logic [8:0] MAX_LEN9  = 9'(MAX_CONTENT % 512);

  typedef struct packed {
    logic [1:0] stage;
    logic       neg;
    logic       take;
    logic [3:0] digit;
  } num_t;

  // one step of the number scanner
  function automatic num_t num_char(input logic [7:0] b, input logic [1:0] st,
                                    input logic neg);
    num_t r;
    logic dig;
    logic sp;
    r.stage = st;
    r.neg   = neg;
    r.take  = 1'b0;
    r.digit = 4'd0;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    sp  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    if ((st == NS_START) && sp) begin
      r.stage = st;
    end else if ((st == NS_START) && (b == CH_PLUS)) begin
      r.stage = NS_SIGN;
    end else if ((st == NS_START) && (b == CH_MINUS)) begin
      r.neg   = 1'b1;
      r.stage = NS_SIGN;
    end else if ((st != NS_DONE) && dig) begin
      r.stage = NS_DIGITS;
      r.take  = 1'b1;
      r.digit = b[3:0];
    end else begin
      r.stage = NS_DONE;
    end
    return r;
  endfunction

  // input register
  logic       pend_r;
  logic [7:0] byte_r;
  logic       last_r;

  // frame state
  logic [2:0]    phase_r, phase_nxt;
  logic [5:0]    cc_r, cc_nxt;
  logic [31:0]   snd_r, snd_nxt;
  logic [31:0]   dst_r, dst_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   ctr_r, ctr_nxt;
  logic          cneg_r, cneg_nxt;
  logic [16:0]   ttl_r, ttl_nxt;
  logic          tflag_r, tflag_nxt;
  logic          tneg_r, tneg_nxt;
  logic [1:0]    ns_r, ns_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    err_r, err_nxt;

  logic          accept;
  logic [31:0]   name_bits;
  logic          name_full;
  num_t          num;
  logic [19:0]   ttl_mul;
  logic          ttl_ok;
  logic [2:0]    st;
  logic [10:0]   cnt_wide;
  chp_result_t   content_res;
  chp_result_t   header_res;
  logic          emit_content;

  // room for two more results behind the byte already held
  assign in_bus.ready = ({1'b0, fifo_level} + (pend_r ? (LVL_W+1)'(2) : '0))
                        <= (LVL_W+1)'(OUT_DEPTH - 2);
  assign accept = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept;
    end
    if (accept) begin
      byte_r <= in_bus.data_byte;
      last_r <= in_bus.last_byte;
    end
  end

  // name character helpers
  assign name_bits = 32'(byte_r) << {cc_r[1:0], 3'b000};
  assign name_full = (7'(cc_r) + 7'd1) >= 7'(NAME_LEN);
  assign ttl_mul   = ({3'b000, ttl_r} << 3) + ({3'b000, ttl_r} << 1) + 20'(num.digit);

  // parse step and result build
  always_comb begin
    phase_nxt    = phase_r;
    cc_nxt       = cc_r;
    snd_nxt      = snd_r;
    dst_nxt      = dst_r;
    kind_nxt     = kind_r;
    ctr_nxt      = ctr_r;
    cneg_nxt     = cneg_r;
    ttl_nxt      = ttl_r;
    tflag_nxt    = tflag_r;
    tneg_nxt     = tneg_r;
    ns_nxt       = ns_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    emit_content = 1'b0;
    num          = num_char(byte_r, ns_r, (phase_r == PH_TTL) ? tneg_r : cneg_r);
    ttl_ok       = 1'b0;
    st           = ST_OK;
    cnt_wide     = '0;
    content_res  = '0;
    header_res   = '0;
    push         = '0;

    if (pend_r) begin
      if (err_r == ST_OK) begin
        unique case (phase_r) inside
          PH_SENDER: begin
            if ((byte_r == CH_AT) || (byte_r == CH_HASH)) begin
              err_nxt = ST_SENDER;
            end else if (byte_r == CH_NUL) begin
              err_nxt = ST_SENDER;
            end else begin
              snd_nxt = snd_r | name_bits;
              cc_nxt  = cc_r + 6'd1;
              if (name_full) phase_nxt = PH_SEEK_MARK;
            end
          end
          PH_SEEK_MARK: begin
            if (byte_r == CH_AT) begin
              kind_nxt  = KIND_CONTACT;
              phase_nxt = PH_DEST_FIRST;
              cc_nxt    = '0;
            end else if (byte_r == CH_HASH) begin
              kind_nxt  = KIND_GROUP;
              phase_nxt = PH_DEST_FIRST;
              cc_nxt    = '0;
            end
          end
          PH_DEST_FIRST, PH_DEST: begin
            if ((phase_r == PH_DEST_FIRST) && (byte_r == CH_STAR)) begin
              if (kind_r == KIND_GROUP) begin
                err_nxt = ST_GROUPBC;
              end else begin
                kind_nxt  = KIND_BCAST;
                dst_nxt   = 32'(CH_STAR);
                phase_nxt = PH_SEEK_COLON;
              end
            end else begin
              phase_nxt = PH_DEST;
              if ((byte_r == CH_COLON) || (byte_r == CH_NUL)) begin
                err_nxt = ST_DEST;
              end else begin
                dst_nxt = dst_r | name_bits;
                cc_nxt  = cc_r + 6'd1;
                if (name_full) phase_nxt = PH_SEEK_COLON;
              end
            end
          end
          PH_SEEK_COLON: begin
            if (byte_r == CH_COLON) begin
              phase_nxt = PH_COUNTER;
              cc_nxt    = '0;
              ns_nxt    = NS_START;
            end
          end
          PH_COUNTER: begin
            if (byte_r == CH_COLON) begin
              phase_nxt = PH_CONTENT;
            end else if (byte_r == CH_COMMA) begin
              phase_nxt = PH_TTL;
              tflag_nxt = 1'b1;
              cc_nxt    = '0;
              ns_nxt    = NS_START;
            end else if (cc_r >= TEXT_MAX) begin
              err_nxt = ST_COUNTER;
            end else begin
              cc_nxt   = cc_r + 6'd1;
              ns_nxt   = num.stage;
              cneg_nxt = num.neg;
              if (num.take) begin
                ctr_nxt = (ctr_r << 3) + (ctr_r << 1) + 32'(num.digit);
              end
            end
          end
          PH_TTL: begin
            if (byte_r == CH_COLON) begin
              if (ttl_r[16] || (tneg_r && (ttl_r != '0))) err_nxt = ST_TTL;
              else phase_nxt = PH_CONTENT;
            end else if (cc_r >= TEXT_MAX) begin
              err_nxt = ST_TTL;
            end else begin
              cc_nxt   = cc_r + 6'd1;
              ns_nxt   = num.stage;
              tneg_nxt = num.neg;
              if (num.take && !ttl_r[16]) begin
                ttl_nxt = (ttl_mul > TTL_SAT) ? 17'(TTL_SAT) : ttl_mul[16:0];
              end
            end
          end
          default: begin
            // content phase
            if (cnt_r >= CW'(MAX_CONTENT)) begin
              err_nxt = ST_LENGTH;
            end else begin
              emit_content = 1'b1;
              cnt_nxt      = cnt_r + CW'(1);
            end
          end
        endcase
      end

      // content transfer result
      content_res.item_kind    = ITEM_CONTENT;
      content_res.content_char = byte_r;
      content_res.run_end      = !last_r;

      // header at frame end, from the updated state
      ttl_ok = !ttl_nxt[16] && !(tneg_nxt && (ttl_nxt != '0));
      if (err_nxt != ST_OK) begin
        st = err_nxt;
      end else begin
        unique case (phase_nxt)
          PH_SENDER:     st = ST_SENDER;
          PH_SEEK_MARK:  st = ST_MARKER;
          PH_DEST_FIRST: st = ST_DEST;
          PH_DEST:       st = ST_DEST;
          PH_SEEK_COLON: st = ST_COUNTER;
          PH_COUNTER:    st = ST_COUNTER;
          PH_TTL:        st = ttl_ok ? ST_LENGTH : ST_TTL;
          default:       st = ST_OK;
        endcase
      end
      cnt_wide              = 11'(cnt_nxt);
      header_res.item_kind  = ITEM_HEADER;
      header_res.status     = st;
      header_res.run_end    = 1'b1;
      if (st == ST_OK) begin
        header_res.dest_kind      = kind_nxt;
        header_res.sender_name    = snd_nxt;
        header_res.dest_name      = dst_nxt;
        header_res.msg_counter    = cneg_nxt ? (32'd0 - ctr_nxt) : ctr_nxt;
        header_res.ttl_present    = tflag_nxt;
        header_res.ttl_value      = (tflag_nxt && !tneg_nxt) ? ttl_nxt[15:0] : 16'd0;
        header_res.content_length = cnt_wide[8:0];
      end else if (st == ST_LENGTH) begin
        header_res.content_length = MAX_LEN9;
      end

      // results handed to the queue
      if (emit_content && last_r) begin
        push.cnt = 2'd2;
        push.r0  = content_res;
        push.r1  = header_res;
      end else if (emit_content) begin
        push.cnt = 2'd1;
        push.r0  = content_res;
      end else if (last_r) begin
        push.cnt = 2'd1;
        push.r0  = header_res;
      end

      // back to the start for the next frame
      if (last_r) begin
        phase_nxt = PH_SENDER;
        cc_nxt    = '0;
        snd_nxt   = '0;
        dst_nxt   = '0;
        kind_nxt  = KIND_BCAST;
        ctr_nxt   = '0;
        cneg_nxt  = 1'b0;
        ttl_nxt   = '0;
        tflag_nxt = 1'b0;
        tneg_nxt  = 1'b0;
        ns_nxt    = NS_START;
        cnt_nxt   = '0;
        err_nxt   = ST_OK;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SENDER;
      cc_r    <= '0;
      snd_r   <= '0;
      dst_r   <= '0;
      kind_r  <= KIND_BCAST;
      ctr_r   <= '0;
      cneg_r  <= 1'b0;
      ttl_r   <= '0;
      tflag_r <= 1'b0;
      tneg_r  <= 1'b0;
      ns_r    <= NS_START;
      cnt_r   <= '0;
      err_r   <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      cc_r    <= cc_nxt;
      snd_r   <= snd_nxt;
      dst_r   <= dst_nxt;
      kind_r  <= kind_nxt;
      ctr_r   <= ctr_nxt;
      cneg_r  <= cneg_nxt;
      ttl_r   <= ttl_nxt;
      tflag_r <= tflag_nxt;
      tneg_r  <= tneg_nxt;
      ns_r    <= ns_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

### rtl/chp_out_fifo.sv
// ----------------------------------------------------------------------------
// chp_out_fifo
// Result queue: takes up to two results a cycle, hands one per transfer.
// ----------------------------------------------------------------------------
module chp_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chp_pkg::chp_push_t         push,
  output logic [chp_pkg::LVL_W-1:0]  fifo_level,
  chp_out_if.source                  out_bus
);
  import chp_pkg::*;

  chp_result_t        mem [OUT_DEPTH];
  logic [OUT_AW-1:0]  wp_r, wp_nxt;
  logic [OUT_AW-1:0]  rp_r, rp_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               pop;
  logic [OUT_AW-1:0]  wp_plus1;
  chp_result_t        head;

  assign pop      = out_bus.valid && out_bus.ready;
  assign wp_plus1 = wp_r + OUT_AW'(1);

  // pointer and fill level update
  always_comb begin
    wp_nxt    = wp_r + OUT_AW'(push.cnt);
    rp_nxt    = pop ? (rp_r + OUT_AW'(1)) : rp_r;
    level_nxt = level_r + LVL_W'(push.cnt) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wp_r]     <= push.r0;
    if (push.cnt == 2'd2) mem[wp_plus1] <= push.r1;
  end

  assign fifo_level = level_r;
  assign head       = mem[rp_r];

  // head of queue onto the result channel
  assign out_bus.valid          = (level_r != '0);
  assign out_bus.item_kind      = head.item_kind;
  assign out_bus.content_char   = head.content_char;
  assign out_bus.status         = head.status;
  assign out_bus.dest_kind      = head.dest_kind;
  assign out_bus.sender_name    = head.sender_name;
  assign out_bus.dest_name      = head.dest_name;
  assign out_bus.msg_counter    = head.msg_counter;
  assign out_bus.ttl_present    = head.ttl_present;
  assign out_bus.ttl_value      = head.ttl_value;
  assign out_bus.content_length = head.content_length;
  assign out_bus.run_end        = head.run_end;

endmodule
